// File: rtl/m2sh_pkg.sv
package m2sh_pkg;

   // hash constants
   localparam logic [31:0] MIX_MUL  = 32'h5bd1e995;
   localparam int          SHIFT_K  = 24;
   localparam int          SHIFT_F1 = 13;
   localparam int          SHIFT_F2 = 15;

   // stream widths
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;
   localparam int DIGEST_W    = 32;
   localparam int PEND_W      = 2;

   // request tuser codes
   localparam logic ACTION_ABSORB  = 1'b0;
   localparam logic ACTION_RESTART = 1'b1;

   // register map
   localparam int                CSR_AW         = 3;
   localparam int                CSR_DW         = 32;
   localparam logic              CSR_SEED_INDEX = 1'b0;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      OP_RESTART,
      OP_WORD,
      OP_TAIL
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [31:0]         data;   // full word for OP_WORD, tail bytes for OP_TAIL
      logic [PEND_W-1:0]   count;  // pending bytes after this item
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KMUL2,
      ST_HMUL,
      ST_FMUL,
      ST_DONE
   } state_type;

endpackage

// File: rtl/m2sh_front.sv
module m2sh_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [m2sh_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               req_tuser,
   input  m2sh_pkg::queue_status_type         q_status,
   output logic                               push,
   output m2sh_pkg::job_type                  job
);

   logic [m2sh_pkg::PEND_W-1:0] count_ff;
   logic [m2sh_pkg::PEND_W-1:0] count_in;
   logic [7:0]                  bytes_ff [3];
   logic [7:0]                  bytes_in [3];

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      count_in    = count_ff;
      bytes_in    = bytes_ff;
      job.op      = m2sh_pkg::OP_TAIL;
      job.data    = '0;
      job.count   = '0;
      if (req_tuser == m2sh_pkg::ACTION_RESTART) begin
         count_in    = '0;
         bytes_in[0] = '0;
         bytes_in[1] = '0;
         bytes_in[2] = '0;
         job.op      = m2sh_pkg::OP_RESTART;
      end else if (count_ff == 2'd3) begin
         // fourth byte completes a little-endian word
         job.op      = m2sh_pkg::OP_WORD;
         job.data    = {req_tdata, bytes_ff[2], bytes_ff[1], bytes_ff[0]};
         count_in    = '0;
         bytes_in[0] = '0;
         bytes_in[1] = '0;
         bytes_in[2] = '0;
      end else begin
         bytes_in[count_ff] = req_tdata;
         count_in           = count_ff + 2'd1;
         job.op             = m2sh_pkg::OP_TAIL;
         job.data           = {8'h00, bytes_in[2], bytes_in[1], bytes_in[0]};
         job.count          = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         bytes_ff[0] <= '0;
         bytes_ff[1] <= '0;
         bytes_ff[2] <= '0;
      end else if (push) begin
         count_ff <= count_in;
         bytes_ff <= bytes_in;
      end
   end

endmodule

// File: rtl/m2sh_queue.sv
module m2sh_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  m2sh_pkg::job_type           job_in,
   input  logic                        pop,
   output m2sh_pkg::job_type           job_out,
   output m2sh_pkg::queue_status_type  status
);

   m2sh_pkg::job_type               entry_ff [m2sh_pkg::QUEUE_DEPTH];
   logic [m2sh_pkg::QUEUE_AW-1:0]   wr_ptr_ff;
   logic [m2sh_pkg::QUEUE_AW-1:0]   rd_ptr_ff;
   logic [m2sh_pkg::QUEUE_AW:0]     fill_ff;
   logic [m2sh_pkg::QUEUE_AW:0]     fill_in;

   assign job_out      = entry_ff[rd_ptr_ff];
   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == (m2sh_pkg::QUEUE_AW + 1)'(m2sh_pkg::QUEUE_DEPTH));

   always_comb begin
      fill_in = fill_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

// File: rtl/m2sh_back.sv
module m2sh_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [31:0]                        seed,
   input  m2sh_pkg::job_type                  job,
   input  m2sh_pkg::queue_status_type         q_status,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [m2sh_pkg::DIGEST_W-1:0]      digest,
   output logic [m2sh_pkg::PEND_W-1:0]        bytes_pending
);

   m2sh_pkg::state_type          state_ff, state_in;
   logic [31:0]                  acc_ff, acc_in;
   logic [31:0]                  k_ff, k_in;
   logic [31:0]                  hash_ff, hash_in;
   logic [m2sh_pkg::PEND_W-1:0]  pend_ff, pend_in;
   logic                         valid_ff, valid_in;
   logic [31:0]                  digest_ff, digest_in;
   logic [m2sh_pkg::PEND_W-1:0]  bp_ff, bp_in;
   logic [31:0]                  mul_a;
   logic [31:0]                  product;
   logic                         out_free;

   // one shared multiplier, low 32 bits only
   assign product  = mul_a * m2sh_pkg::MIX_MUL;
   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      k_in      = k_ff;
      hash_in   = hash_ff;
      pend_in   = pend_ff;
      valid_in  = valid_ff && !rsp_tready;
      digest_in = digest_ff;
      bp_in     = bp_ff;
      pop       = 1'b0;
      mul_a     = acc_ff ^ (acc_ff >> m2sh_pkg::SHIFT_F1);
      unique case (state_ff)
         m2sh_pkg::ST_IDLE: begin
            if (!q_status.empty) begin
               pop     = 1'b1;
               pend_in = job.count;
               unique case (job.op)
                  m2sh_pkg::OP_RESTART: begin
                     hash_in  = seed;
                     acc_in   = seed;
                     state_in = m2sh_pkg::ST_FMUL;
                  end
                  m2sh_pkg::OP_WORD: begin
                     mul_a    = job.data;
                     acc_in   = product;
                     state_in = m2sh_pkg::ST_KMUL2;
                  end
                  m2sh_pkg::OP_TAIL: begin
                     // tail xor and its multiply in one go
                     mul_a    = hash_ff ^ job.data;
                     acc_in   = product;
                     state_in = m2sh_pkg::ST_FMUL;
                  end
                  default: begin
                     state_in = m2sh_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         m2sh_pkg::ST_KMUL2: begin
            mul_a    = acc_ff ^ (acc_ff >> m2sh_pkg::SHIFT_K);
            k_in     = product;
            state_in = m2sh_pkg::ST_HMUL;
         end
         m2sh_pkg::ST_HMUL: begin
            mul_a    = hash_ff;
            hash_in  = product ^ k_ff;
            acc_in   = product ^ k_ff;
            state_in = m2sh_pkg::ST_FMUL;
         end
         m2sh_pkg::ST_FMUL: begin
            mul_a    = acc_ff ^ (acc_ff >> m2sh_pkg::SHIFT_F1);
            acc_in   = product;
            state_in = m2sh_pkg::ST_DONE;
         end
         m2sh_pkg::ST_DONE: begin
            if (out_free) begin
               valid_in  = 1'b1;
               digest_in = acc_ff ^ (acc_ff >> m2sh_pkg::SHIFT_F2);
               bp_in     = pend_ff;
               state_in  = m2sh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = m2sh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= m2sh_pkg::ST_IDLE;
         valid_ff <= 1'b0;
         hash_ff  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         hash_ff  <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      k_ff      <= k_in;
      pend_ff   <= pend_in;
      digest_ff <= digest_in;
      bp_ff     <= bp_in;
   end

   assign rsp_tvalid    = valid_ff;
   assign digest        = digest_ff;
   assign bytes_pending = bp_ff;

`ifndef SYNTHESIS
   a_kmul_to_hmul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == m2sh_pkg::ST_KMUL2) |=> (state_ff == m2sh_pkg::ST_HMUL))
      else $error("word mix did not proceed to hash fold");

   a_done_loads_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == m2sh_pkg::ST_DONE && out_free) |=> valid_ff)
      else $error("finished digest not presented");

   a_short_job_to_final: assert property (@(posedge clock) disable iff (reset)
      (pop && job.op != m2sh_pkg::OP_WORD) |=> (state_ff == m2sh_pkg::ST_FMUL))
      else $error("restart or tail job skipped finalisation");

   a_word_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (pop && job.op == m2sh_pkg::OP_WORD) |=> (pend_ff == '0))
      else $error("completed word left pending bytes");
`endif

endmodule

// File: rtl/murmur2_stream_hash.sv
// byte-serial murmurhash2 (32-bit) with a digest returned for every item
// request stream: req_tuser selects restart (1) or absorb (0), req_tdata the byte.
// result stream: one item per request, digest of all bytes since the last restart
// plus the count of bytes still waiting for a full word.
// seed register at csr byte address 0; the hash takes it up only on a restart item.
// a front stage assembles bytes into words and queues jobs (four deep); a back
// sequencer with one 32x32 multiplier mixes and finalises, one multiply a cycle.
// in the back a byte completing a word passes through ST_IDLE, ST_KMUL2, ST_HMUL,
// ST_FMUL and ST_DONE; other items go from ST_IDLE straight to ST_FMUL and ST_DONE.
// sustained rate is set by the shared multiplier; the back takes no new job until ST_DONE.
// while the receiver stalls the result stays in the output register; the back
// holds the next digest and the queue absorbs up to four further requests,
// after which req_tready drops.
// reset clears the seed, running hash, pending bytes, queue and output valid.
module murmur2_stream_hash (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [m2sh_pkg::REQ_TDATA_W-1:0]   req_tdata,   // [7:0] data_byte
   input  logic                               req_tuser,   // [0] action
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [m2sh_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // [31:0] digest, [33:32] bytes_pending
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [m2sh_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [m2sh_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [m2sh_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                               csr_pready
);

   logic [31:0]                      seed_ff;
   logic                             csr_wr;
   logic                             push;
   logic                             pop;
   m2sh_pkg::job_type                job_front;
   m2sh_pkg::job_type                job_head;
   m2sh_pkg::queue_status_type       q_status;
   logic [m2sh_pkg::DIGEST_W-1:0]    digest;
   logic [m2sh_pkg::PEND_W-1:0]      bytes_pending;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == m2sh_pkg::CSR_SEED_INDEX) ? seed_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_wr && csr_paddr[2] == m2sh_pkg::CSR_SEED_INDEX) begin
         seed_ff <= csr_pwdata;
      end
   end

   m2sh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .push       (push),
      .job        (job_front)
   );

   m2sh_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .job_in  (job_front),
      .pop     (pop),
      .job_out (job_head),
      .status  (q_status)
   );

   m2sh_back u_back (
      .clock         (clock),
      .reset         (reset),
      .seed          (seed_ff),
      .job           (job_head),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .digest        (digest),
      .bytes_pending (bytes_pending)
   );

   assign rsp_tdata = {6'b000000, bytes_pending, digest};

endmodule

// File: tb/murmur2_stream_hash_tb.sv
module murmur2_stream_hash_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS   = 125;

   localparam logic [m2sh_pkg::CSR_AW-1:0] SEED_ADDR   = {m2sh_pkg::CSR_SEED_INDEX, 2'b00};
   localparam logic [m2sh_pkg::CSR_AW-1:0] UNUSED_ADDR = {~m2sh_pkg::CSR_SEED_INDEX, 2'b00};

   typedef struct packed {
      logic [m2sh_pkg::DIGEST_W-1:0] digest;
      logic [m2sh_pkg::PEND_W-1:0]   pending;
   } digest_result_type;

   // running murmurhash2 state and the digests still owed by the block
   class digest_scoreboard;
      logic [31:0]       seed_value;
      logic [31:0]       running_hash;
      logic [7:0]        tail_bytes [3];
      int unsigned       tail_count;
      digest_result_type owed_q [$];

      function new();
         seed_value   = '0;
         running_hash = '0;
         tail_count   = 0;
         foreach (tail_bytes[i]) tail_bytes[i] = '0;
      endfunction

      function void set_seed(logic [31:0] value);
         seed_value = value;
      endfunction

      function int outstanding();
         return owed_q.size();
      endfunction

      function logic [31:0] mix_word(logic [31:0] k);
         k = k * m2sh_pkg::MIX_MUL;
         k ^= k >> m2sh_pkg::SHIFT_K;
         k = k * m2sh_pkg::MIX_MUL;
         return k;
      endfunction

      function logic [31:0] finalise();
         logic [31:0] h;
         h = running_hash;
         if (tail_count != 0) begin
            if (tail_count >= 3) h ^= {8'h00, tail_bytes[2], 16'h0000};
            if (tail_count >= 2) h ^= {16'h0000, tail_bytes[1], 8'h00};
            h ^= {24'h000000, tail_bytes[0]};
            h = h * m2sh_pkg::MIX_MUL;
         end
         h ^= h >> m2sh_pkg::SHIFT_F1;
         h = h * m2sh_pkg::MIX_MUL;
         h ^= h >> m2sh_pkg::SHIFT_F2;
         return h;
      endfunction

      function void note_item(logic action, logic [7:0] data_byte);
         digest_result_type res;
         logic [31:0]       k;
         if (action == m2sh_pkg::ACTION_RESTART) begin
            running_hash = seed_value;
            tail_count   = 0;
            foreach (tail_bytes[i]) tail_bytes[i] = '0;
         end else if (tail_count >= 3) begin
            k = {data_byte, tail_bytes[2], tail_bytes[1], tail_bytes[0]};
            running_hash = (running_hash * m2sh_pkg::MIX_MUL) ^ mix_word(k);
            tail_count   = 0;
            foreach (tail_bytes[i]) tail_bytes[i] = '0;
         end else begin
            tail_bytes[tail_count] = data_byte;
            tail_count++;
         end
         res.digest  = finalise();
         res.pending = tail_count[m2sh_pkg::PEND_W-1:0];
         owed_q.push_back(res);
      endfunction

      // returns the number of wrong fields, with a line describing them
      function int check_digest(logic [m2sh_pkg::DIGEST_W-1:0] digest,
                                logic [m2sh_pkg::PEND_W-1:0] pending,
                                output string why);
         digest_result_type exp;
         int                bad;
         bad = 0;
         why = "";
         if (owed_q.size() == 0) begin
            why = $sformatf("result item with nothing outstanding: digest %h pending %0d",
                            digest, pending);
            return 1;
         end
         exp = owed_q.pop_front();
         if (digest !== exp.digest) begin
            bad++;
            why = $sformatf("digest %h, expected %h;", digest, exp.digest);
         end
         if (pending !== exp.pending) begin
            bad++;
            why = $sformatf("%s bytes_pending %0d, expected %0d", why, pending, exp.pending);
         end
         return bad;
      endfunction
   endclass

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_tvalid  = 1'b0;
   logic                                req_tready;
   logic [m2sh_pkg::REQ_TDATA_W-1:0]    req_tdata   = '0;   // [7:0] data_byte
   logic                                req_tuser   = m2sh_pkg::ACTION_ABSORB;   // [0] action
   logic                                rsp_tvalid;
   logic                                rsp_tready  = 1'b0;
   logic [m2sh_pkg::RSP_TDATA_W-1:0]    rsp_tdata;   // [31:0] digest, [33:32] bytes_pending
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [m2sh_pkg::CSR_AW-1:0]         csr_paddr   = '0;
   logic [m2sh_pkg::CSR_DW-1:0]         csr_pwdata  = '0;
   logic [m2sh_pkg::CSR_DW-1:0]         csr_prdata;
   logic                                csr_pready;

   digest_scoreboard sb = new();
   int  error_count = 0;
   int  cycle_count = 0;
   int  send_idle   = 0;
   int  recv_stall  = 0;
   int  idle_plan  [4] = '{0, 52, 0, 36};
   int  stall_plan [4] = '{0, 0, 52, 36};
   logic [31:0] seed_plan [4];

   murmur2_stream_hash uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("murmur2_stream_hash test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      string why;
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_item(req_tuser, req_tdata[7:0]);
         if (rsp_tvalid && rsp_tready) begin
            if (sb.check_digest(rsp_tdata[31:0], rsp_tdata[33:32], why) != 0) report(why);
         end
      end
   end

   // valid stays high between back-to-back items; it drops only in a gap
   task automatic send_item(input logic action, input logic [7:0] data_byte);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= data_byte;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [m2sh_pkg::CSR_AW-1:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == SEED_ADDR) sb.set_seed(value);
      @(posedge clock);
   endtask

   initial begin
      seed_plan[0] = 32'hffff_ffff;
      seed_plan[1] = 32'h0000_0000;
      seed_plan[2] = $urandom;
      seed_plan[3] = $urandom;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bytes completing a word, then restart with junk in the data byte
      send_item(m2sh_pkg::ACTION_ABSORB, 8'h00);
      send_item(m2sh_pkg::ACTION_ABSORB, 8'hff);
      send_item(m2sh_pkg::ACTION_ABSORB, 8'h80);
      send_item(m2sh_pkg::ACTION_ABSORB, 8'h01);
      send_item(m2sh_pkg::ACTION_RESTART, 8'hff);
      repeat (4) send_item(m2sh_pkg::ACTION_ABSORB, 8'hff);
      send_item(m2sh_pkg::ACTION_ABSORB, 8'h7f);
      send_item(m2sh_pkg::ACTION_ABSORB, 8'h5a);
      drain();
      // new seed mid-message must not touch the running hash
      csr_write(SEED_ADDR, 32'hffff_ffff);
      csr_write(UNUSED_ADDR, 32'h1234_5678);
      send_item(m2sh_pkg::ACTION_ABSORB, 8'hc3);
      send_item(m2sh_pkg::ACTION_ABSORB, 8'h3c);
      send_item(m2sh_pkg::ACTION_RESTART, 8'h00);
      repeat (4) send_item(m2sh_pkg::ACTION_ABSORB, 8'h00);
      send_item(m2sh_pkg::ACTION_ABSORB, 8'hff);
      send_item(m2sh_pkg::ACTION_RESTART, 8'haa);
      send_item(m2sh_pkg::ACTION_RESTART, 8'h55);
      send_item(m2sh_pkg::ACTION_ABSORB, 8'h96);

      for (int p = 0; p < 4; p++) begin
         drain();
         send_idle  = idle_plan[p];
         recv_stall = stall_plan[p];
         csr_write(SEED_ADDR, seed_plan[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == PHASE_ITEMS / 2) drain();
            if ($urandom_range(9) == 0)
               send_item(m2sh_pkg::ACTION_RESTART, 8'($urandom_range(255)));
            else
               send_item(m2sh_pkg::ACTION_ABSORB, 8'($urandom_range(255)));
         end
      end
      drain();

      if (sb.outstanding() != 0)
         report($sformatf("%0d result items never arrived", sb.outstanding()));
      if (error_count == 0) begin
         $display("murmur2_stream_hash test passed");
      end else begin
         $display("murmur2_stream_hash test failed");
      end
      $finish;
   end

endmodule
